// File: hw/rtl/esc_throttle_steer_sequencer_core_defines.svh
// assertion macros for the esc throttle / steer sequencer
// expects signals clk and rst in the scope of each use
`ifndef ESC_THROTTLE_STEER_SEQUENCER_CORE_DEFINES_SVH
`define ESC_THROTTLE_STEER_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define ESC_TSS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("esc_tss: invariant violated");

`define ESC_TSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esc_tss: same-cycle implication violated");

`define ESC_TSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esc_tss: next-cycle implication violated");

`else

`define ESC_TSS_ASSERT_ALWAYS(lbl, expr)

`define ESC_TSS_ASSERT_IMPL(lbl, ante, cons)

`define ESC_TSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/esc_tss_pkg.sv
// shared types, codes and widths for the esc throttle / steer sequencer
// no dependencies
`default_nettype none

package esc_tss_pkg;

  localparam int PWM_BITS   = 12;
  localparam int CNT_W      = 12;
  localparam int ANG_W      = 9;
  localparam int PCT_W      = 8;
  localparam int CMD_W      = 2;
  localparam int WAIT_W     = 2;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // mapping datapath widths
  localparam int OPA_W  = ANG_W + 2;
  localparam int OPB_W  = CNT_W + 1;
  localparam int OFFB_W = ANG_W + 1;
  localparam int ACC_W  = OPA_W + OPB_W;
  localparam int OFFP_W = OPB_W + OFFB_W;
  localparam int NUM_W  = ACC_W + 2;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DEN_W  = ANG_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic signed [OFFB_W-1:0] THR_SPAN = OFFB_W'(100);

  // queue sizes
  localparam int JQ_DEPTH = 2;
  localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
  localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // register reset values
  localparam logic [CNT_W-1:0]        RST_NEUTRAL = CNT_W'(369);
  localparam logic [CNT_W-1:0]        RST_FORWARD = CNT_W'(500);
  localparam logic [CNT_W-1:0]        RST_REVERSE = CNT_W'(250);
  localparam logic [CNT_W-1:0]        RST_RIGHT   = CNT_W'(300);
  localparam logic [CNT_W-1:0]        RST_LEFT    = CNT_W'(450);
  localparam logic signed [ANG_W-1:0] RST_FLOOR   = -ANG_W'(60);
  localparam logic signed [ANG_W-1:0] RST_CEILING = ANG_W'(60);

  localparam logic [WAIT_W-1:0] HOLD_NONE  = WAIT_W'(0);
  localparam logic [WAIT_W-1:0] HOLD_SHORT = WAIT_W'(1);
  localparam logic [WAIT_W-1:0] HOLD_LONG  = WAIT_W'(2);

  localparam logic signed [DIR_W-1:0] DIR_REV  = -DIR_W'(1);
  localparam logic signed [DIR_W-1:0] DIR_STOP = DIR_W'(0);
  localparam logic signed [DIR_W-1:0] DIR_FWD  = DIR_W'(1);

  localparam logic CH_THROTTLE = 1'b0;
  localparam logic CH_STEER    = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_THROTTLE = 2'd0,
    CMD_BRAKE    = 2'd1,
    CMD_STEER    = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEUTRAL       = 3'd0,
    REG_FULL_FORWARD  = 3'd1,
    REG_FULL_REVERSE  = 3'd2,
    REG_STEER_RIGHT   = 3'd3,
    REG_STEER_LEFT    = 3'd4,
    REG_ANGLE_FLOOR   = 3'd5,
    REG_ANGLE_CEILING = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_THROTTLE,
    JOB_BRAKE,
    JOB_STEER
  } job_op_t;

  typedef struct packed {
    job_op_t                   op;
    logic signed [DIR_W-1:0]   old_dir;
    logic signed [DIR_W-1:0]   new_dir;
    logic                      counter;  // counter pulse and neutral come first
    logic                      neg;      // reverse throttle demand
    logic [PCT_W-1:0]          mag;      // throttle magnitude
    logic signed [ANG_W-1:0]   angle;
  } job_t;

  typedef struct packed {
    logic [CNT_W-1:0]        neutral;
    logic [CNT_W-1:0]        full_forward;
    logic [CNT_W-1:0]        full_reverse;
    logic [CNT_W-1:0]        steer_right;
    logic [CNT_W-1:0]        steer_left;
    logic signed [ANG_W-1:0] angle_floor;
    logic signed [ANG_W-1:0] angle_ceiling;
  } cfg_t;

  typedef struct packed {
    logic                    channel;
    logic [CNT_W-1:0]        pwm_count;
    logic [WAIT_W-1:0]       wait_after;
    logic signed [DIR_W-1:0] drive_direction;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PULSE,
    BK_NEUTRAL,
    BK_SETUP,
    BK_FLAT,
    BK_MUL,
    BK_ACC,
    BK_START,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/esc_throttle_steer_sequencer_core.sv
// top level of the esc throttle / steer sequencer: config registers and wiring
// depends on esc_tss_pkg, esc_tss_front, esc_tss_back and esc_tss_outq
//
// Commands enter through a queue-style port: a transaction is taken at a clock
// edge with push high and full low. Results leave the same way: the oldest
// result sits on the result ports while empty is low and is taken with pop.
// A command gives zero to three results; the last one carries last high.
// The front end takes commands into a two-entry job queue and keeps the drive
// direction, so it holds up to two jobs ahead of the back end.
// The back end works one job at a time: a counter pulse and then neutral when
// the drive reverses or brakes while moving, neutral alone for a brake from
// rest, and for throttle or steer a map through setup, multiply, accumulate
// and the 25-step restoring divider that the back end shares between both
// maps; a steer whose angle bounds are equal skips the map.
// A stalled receiver fills the four-entry result queue; the back end then
// waits, then the job queue fills and full rises. Nothing is dropped.
// Synchronous reset clears both queues, sets the direction to stopped and
// loads the register defaults. Register writes take effect at once and are
// meant to be made while no transaction is in flight.
`default_nettype none

module esc_throttle_steer_sequencer_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     full,
  input  logic [esc_tss_pkg::CMD_W-1:0]            command,
  input  logic signed [esc_tss_pkg::PCT_W-1:0]     throttle_percent,
  input  logic signed [esc_tss_pkg::ANG_W-1:0]     steer_angle,
  output logic                                     empty,
  input  logic                                     pop,
  output logic                                     channel,
  output logic [esc_tss_pkg::CNT_W-1:0]            pwm_count,
  output logic [esc_tss_pkg::WAIT_W-1:0]           wait_after,
  output logic signed [esc_tss_pkg::DIR_W-1:0]     drive_direction,
  output logic                                     last,
  input  logic                                     cfg_write,
  input  logic [esc_tss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [esc_tss_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import esc_tss_pkg::*;

  cfg_t    cfg;
  logic    job_valid;
  job_t    job;
  logic    job_pop;
  logic    rpush;
  result_t ritem;
  logic    rfull;
  result_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.neutral       <= RST_NEUTRAL;
      cfg.full_forward  <= RST_FORWARD;
      cfg.full_reverse  <= RST_REVERSE;
      cfg.steer_right   <= RST_RIGHT;
      cfg.steer_left    <= RST_LEFT;
      cfg.angle_floor   <= RST_FLOOR;
      cfg.angle_ceiling <= RST_CEILING;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NEUTRAL:       cfg.neutral       <= cfg_data[CNT_W-1:0];
        REG_FULL_FORWARD:  cfg.full_forward  <= cfg_data[CNT_W-1:0];
        REG_FULL_REVERSE:  cfg.full_reverse  <= cfg_data[CNT_W-1:0];
        REG_STEER_RIGHT:   cfg.steer_right   <= cfg_data[CNT_W-1:0];
        REG_STEER_LEFT:    cfg.steer_left    <= cfg_data[CNT_W-1:0];
        REG_ANGLE_FLOOR:   cfg.angle_floor   <= cfg_data[ANG_W-1:0];
        REG_ANGLE_CEILING: cfg.angle_ceiling <= cfg_data[ANG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  esc_tss_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .command          (command),
    .throttle_percent (throttle_percent),
    .steer_angle      (steer_angle),
    .job_pop          (job_pop),
    .job_valid        (job_valid),
    .job              (job)
  );

  esc_tss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .rpush     (rpush),
    .ritem     (ritem),
    .rfull     (rfull)
  );

  esc_tss_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (rpush),
    .item  (ritem),
    .full  (rfull),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign channel         = head.channel;
  assign pwm_count       = head.pwm_count;
  assign wait_after      = head.wait_after;
  assign drive_direction = head.drive_direction;
  assign last            = head.last;

endmodule

`default_nettype wire

// File: hw/rtl/esc_tss_front.sv
// front end: accepts commands, tracks drive direction, queues decoded jobs
// depends on esc_tss_pkg and the assertion macro header
`default_nettype none
`include "esc_throttle_steer_sequencer_core_defines.svh"

module esc_tss_front (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     full,
  input  logic [esc_tss_pkg::CMD_W-1:0]            command,
  input  logic signed [esc_tss_pkg::PCT_W-1:0]     throttle_percent,
  input  logic signed [esc_tss_pkg::ANG_W-1:0]     steer_angle,
  input  logic                                     job_pop,
  output logic                                     job_valid,
  output esc_tss_pkg::job_t                        job
);
  import esc_tss_pkg::*;

  logic signed [DIR_W-1:0] direction;
  logic signed [DIR_W-1:0] direction_next;
  job_t                    new_job;
  logic                    has_job;
  logic                    accept;
  logic                    jq_push;

  job_t                    jq [JQ_DEPTH];
  logic [JQ_PTR_W-1:0]     wr_ptr;
  logic [JQ_PTR_W-1:0]     rd_ptr;
  logic [JQ_CNT_W-1:0]     jq_count;

  assign full    = (jq_count == JQ_CNT_W'(JQ_DEPTH));
  assign accept  = push && !full;
  assign jq_push = accept && has_job;

  // classify the command and work out the direction it leaves behind
  always_comb begin
    new_job         = '0;
    new_job.op      = JOB_STEER;
    new_job.old_dir = direction;
    new_job.new_dir = direction;
    new_job.angle   = steer_angle;
    new_job.neg     = throttle_percent[PCT_W-1];
    new_job.mag     = throttle_percent[PCT_W-1] ? PCT_W'(-throttle_percent)
                                                : PCT_W'(throttle_percent);
    has_job         = 1'b0;
    direction_next  = direction;
    case (command)
      CMD_THROTTLE: begin
        if (throttle_percent != '0) begin
          has_job         = 1'b1;
          new_job.op      = JOB_THROTTLE;
          new_job.new_dir = new_job.neg ? DIR_REV : DIR_FWD;
          new_job.counter = (direction == (new_job.neg ? DIR_FWD : DIR_REV));
          direction_next  = new_job.new_dir;
        end
      end
      CMD_BRAKE: begin
        has_job         = 1'b1;
        new_job.op      = JOB_BRAKE;
        new_job.new_dir = DIR_STOP;
        new_job.counter = (direction != DIR_STOP);
        direction_next  = DIR_STOP;
      end
      CMD_STEER: begin
        has_job = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_STOP;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      jq_count  <= '0;
    end else begin
      if (accept) begin
        direction <= direction_next;
      end
      if (jq_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (job_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({jq_push, job_pop})
        2'b10:   jq_count <= jq_count + 1'b1;
        2'b01:   jq_count <= jq_count - 1'b1;
        default: jq_count <= jq_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (jq_push) begin
      jq[wr_ptr] <= new_job;
    end
  end

  assign job_valid = (jq_count != '0);
  assign job       = jq[rd_ptr];

  `ESC_TSS_ASSERT_ALWAYS(a_jq_bound, jq_count <= JQ_CNT_W'(JQ_DEPTH))
  `ESC_TSS_ASSERT_IMPL(a_pop_has_job, job_pop, job_valid)

endmodule

`default_nettype wire

// File: hw/rtl/esc_tss_div.sv
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on esc_tss_pkg and the assertion macro header
`default_nettype none
`include "esc_throttle_steer_sequencer_core_defines.svh"

module esc_tss_div (
  input  logic                  clk,
  input  logic                  rst,
  input  esc_tss_pkg::div_req_t req,
  output esc_tss_pkg::div_rsp_t rsp
);
  import esc_tss_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [MAG_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  rem_diff;
  logic              fits;
  logic              start;

  assign start    = req.start;
  assign rem_sh   = {rem, quo[MAG_W-1]};
  assign fits     = (rem_sh >= {1'b0, den});
  assign rem_diff = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIV_STEPS - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      quo <= {quo[MAG_W-2:0], fits};
      rem <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  `ESC_TSS_ASSERT_IMPL(a_start_when_idle, start, !busy)
  `ESC_TSS_ASSERT_NEXT(a_done_after_last_step, busy && (step == '0), done)

endmodule

`default_nettype wire

// File: hw/rtl/esc_tss_back.sv
// back end: carries out queued jobs, sequences pulses and runs the linear maps
// depends on esc_tss_pkg, esc_tss_div and the assertion macro header
`default_nettype none
`include "esc_throttle_steer_sequencer_core_defines.svh"

module esc_tss_back (
  input  logic                     clk,
  input  logic                     rst,
  input  esc_tss_pkg::cfg_t        cfg,
  input  logic                     job_valid,
  input  esc_tss_pkg::job_t        job,
  output logic                     job_pop,
  output logic                     rpush,
  output esc_tss_pkg::result_t     ritem,
  input  logic                     rfull
);
  import esc_tss_pkg::*;

  back_state_t state;
  back_state_t state_next;

  job_t                     job_r;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [OPB_W-1:0]  off_a;
  logic signed [OFFB_W-1:0] off_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [NUM_W-1:0]  num;
  logic                     res_neg;
  logic [MAG_W-1:0]         quo_r;

  // setup datapath
  logic signed [ANG_W-1:0]  a_lim;
  logic signed [ANG_W-1:0]  a_cl;
  logic signed [OPA_W-1:0]  steer_x;
  logic signed [OFFB_W-1:0] span;
  logic                     steer_flat;
  logic [CNT_W-1:0]         thr_sel;
  logic signed [OPB_W-1:0]  thr_b;
  logic signed [OPB_W-1:0]  steer_b;

  // multiply / sign datapath
  logic signed [ACC_W-1:0]  prod_main;
  logic signed [OFFP_W-1:0] prod_off;
  logic signed [NUM_W-1:0]  num_sum;
  logic                     num_neg;
  logic                     den_neg;
  logic [NUM_W-1:0]         num_abs;
  logic [OFFB_W-1:0]        den_abs;
  logic [PWM_BITS-1:0]      sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  esc_tss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // floor first, then ceiling, so an inverted pair resolves to the ceiling
  assign a_lim      = (job_r.angle < cfg.angle_floor) ? cfg.angle_floor : job_r.angle;
  assign a_cl       = (a_lim > cfg.angle_ceiling) ? cfg.angle_ceiling : a_lim;
  assign steer_x    = -OPA_W'(a_cl) - OPA_W'(cfg.angle_floor);
  assign span       = OFFB_W'(cfg.angle_ceiling) - OFFB_W'(cfg.angle_floor);
  assign steer_flat = (cfg.angle_ceiling == cfg.angle_floor);
  assign thr_sel    = job_r.neg ? cfg.full_reverse : cfg.full_forward;
  assign thr_b      = $signed({1'b0, thr_sel}) - $signed({1'b0, cfg.neutral});
  assign steer_b    = $signed({1'b0, cfg.steer_left}) - $signed({1'b0, cfg.steer_right});

  assign prod_main = mul_a * mul_b;
  assign prod_off  = off_a * off_b;
  assign num_sum   = NUM_W'(acc) + NUM_W'(prod_off);

  // truncation toward zero: divide magnitudes, sign applied afterwards
  assign num_neg = num[NUM_W-1];
  assign den_neg = off_b[OFFB_W-1];
  assign num_abs = num_neg ? NUM_W'(-num) : NUM_W'(num);
  assign den_abs = den_neg ? OFFB_W'(-off_b) : OFFB_W'(off_b);

  always_comb begin
    if (res_neg) begin
      sat = '0;
    end else if (|quo_r[MAG_W-1:PWM_BITS]) begin
      sat = '1;
    end else begin
      sat = quo_r[PWM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    job_pop          = 1'b0;
    rpush            = 1'b0;
    ritem            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = num_abs[MAG_W-1:0];
    div_req.divisor  = den_abs[DEN_W-1:0];
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.counter) begin
            state_next = BK_PULSE;
          end else if (job.op == JOB_BRAKE) begin
            state_next = BK_NEUTRAL;
          end else begin
            state_next = BK_SETUP;
          end
        end
      end
      BK_PULSE: begin
        ritem.channel         = CH_THROTTLE;
        ritem.pwm_count       = (job_r.old_dir == DIR_REV) ? cfg.full_forward
                                                           : cfg.full_reverse;
        ritem.wait_after      = HOLD_LONG;
        ritem.drive_direction = job_r.old_dir;
        ritem.last            = 1'b0;
        if (!rfull) begin
          rpush      = 1'b1;
          state_next = BK_NEUTRAL;
        end
      end
      BK_NEUTRAL: begin
        ritem.channel         = CH_THROTTLE;
        ritem.pwm_count       = cfg.neutral;
        ritem.wait_after      = job_r.counter ? HOLD_LONG : HOLD_SHORT;
        ritem.drive_direction = DIR_STOP;
        ritem.last            = (job_r.op == JOB_BRAKE);
        if (!rfull) begin
          rpush      = 1'b1;
          state_next = (job_r.op == JOB_BRAKE) ? BK_IDLE : BK_SETUP;
        end
      end
      BK_SETUP: begin
        if ((job_r.op == JOB_STEER) && steer_flat) begin
          state_next = BK_FLAT;
        end else begin
          state_next = BK_MUL;
        end
      end
      BK_FLAT: begin
        ritem.channel         = CH_STEER;
        ritem.pwm_count       = cfg.steer_right;
        ritem.wait_after      = HOLD_NONE;
        ritem.drive_direction = job_r.new_dir;
        ritem.last            = 1'b1;
        if (!rfull) begin
          rpush      = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_MUL: begin
        state_next = BK_ACC;
      end
      BK_ACC: begin
        state_next = BK_START;
      end
      BK_START: begin
        div_req.start = 1'b1;
        state_next    = BK_DIV;
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        ritem.channel         = (job_r.op == JOB_STEER) ? CH_STEER : CH_THROTTLE;
        ritem.pwm_count       = CNT_W'(sat);
        ritem.wait_after      = HOLD_NONE;
        ritem.drive_direction = job_r.new_dir;
        ritem.last            = 1'b1;
        if (!rfull) begin
          rpush      = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // map operands: num = mul_a * mul_b + off_a * off_b, den = off_b
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          job_r <= job;
        end
      end
      BK_SETUP: begin
        if (job_r.op == JOB_STEER) begin
          mul_a <= steer_x;
          mul_b <= steer_b;
          off_a <= $signed({1'b0, cfg.steer_right});
          off_b <= span;
        end else begin
          mul_a <= OPA_W'($signed({1'b0, job_r.mag}));
          mul_b <= thr_b;
          off_a <= $signed({1'b0, cfg.neutral});
          off_b <= THR_SPAN;
        end
      end
      BK_MUL: begin
        acc <= prod_main;
      end
      BK_ACC: begin
        num <= num_sum;
      end
      BK_START: begin
        res_neg <= num_neg ^ den_neg;
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          quo_r <= div_rsp.quotient;
        end
      end
      default: begin
      end
    endcase
  end

  `ESC_TSS_ASSERT_NEXT(a_last_ends_job, rpush && !rfull && ritem.last, state == BK_IDLE)

endmodule

`default_nettype wire

// File: hw/rtl/esc_tss_outq.sv
// result queue between the back end and the result ports
// depends on esc_tss_pkg and the assertion macro header
`default_nettype none
`include "esc_throttle_steer_sequencer_core_defines.svh"

module esc_tss_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  esc_tss_pkg::result_t item,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output esc_tss_pkg::result_t head
);
  import esc_tss_pkg::*;

  result_t             mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] count;
  logic                do_pop;

  assign full   = (count == RQ_CNT_W'(RQ_DEPTH));
  assign empty  = (count == '0);
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  assign head = mem[rd_ptr];

  `ESC_TSS_ASSERT_IMPL(a_no_push_when_full, push, !full)

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for esc_throttle_steer_sequencer_core: directed and random commands
// under several register settings, with results predicted in the bench itself
// depends on esc_tss_pkg and the core rtl

module testbench;
  import esc_tss_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [PCT_W-1:0] pct;
    logic signed [ANG_W-1:0] angle;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [CMD_W-1:0] command = '0;
  logic signed [PCT_W-1:0] throttle_percent = '0;
  logic signed [ANG_W-1:0] steer_angle = '0;
  logic empty;
  logic pop = 1'b0;
  logic channel;
  logic [CNT_W-1:0] pwm_count;
  logic [WAIT_W-1:0] wait_after;
  logic signed [DIR_W-1:0] drive_direction;
  logic last;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  esc_throttle_steer_sequencer_core u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .command(command), .throttle_percent(throttle_percent), .steer_angle(steer_angle),
    .empty(empty), .pop(pop),
    .channel(channel), .pwm_count(pwm_count), .wait_after(wait_after),
    .drive_direction(drive_direction), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench copy of the registers and the drive direction
  cfg_t shadow_cfg = '{neutral: RST_NEUTRAL, full_forward: RST_FORWARD,
                       full_reverse: RST_REVERSE, steer_right: RST_RIGHT,
                       steer_left: RST_LEFT, angle_floor: RST_FLOOR,
                       angle_ceiling: RST_CEILING};
  logic signed [DIR_W-1:0] drive_dir = DIR_STOP;

  cmd_item_t cmd_backlog[$];
  result_t   pwm_expected[$];

  int fail_count = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int n_throttle = 0, n_brake = 0, n_steer = 0, n_unused = 0;
  int send_gap = 0, send_steady = 0;
  int take_gap = 0, take_steady = 0;
  result_t want;

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(inout int steady);
    int roll;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) steady = $urandom_range(10, 30);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // exact rational map, truncated toward zero
  function automatic longint lin_scale(longint x, longint ilo, longint ihi,
                                       longint olo, longint ohi);
    longint den, num;
    den = ihi - ilo;
    num = (x - ilo) * (ohi - olo) + olo * den;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    return num / den;
  endfunction

  function automatic logic [CNT_W-1:0] clip_count(longint v);
    longint top;
    top = (longint'(1) << PWM_BITS) - 1;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return CNT_W'(v);
  endfunction

  function automatic void note_result(logic ch, logic [CNT_W-1:0] cnt,
                                      logic [WAIT_W-1:0] hold,
                                      logic signed [DIR_W-1:0] dir, logic fin);
    result_t r;
    r.channel = ch;
    r.pwm_count = cnt;
    r.wait_after = hold;
    r.drive_direction = dir;
    r.last = fin;
    pwm_expected.push_back(r);
  endfunction

  function automatic void sequence_command(cmd_item_t it);
    longint p, a, lo, hi, n, f, r;
    n = longint'(shadow_cfg.neutral);
    f = longint'(shadow_cfg.full_forward);
    r = longint'(shadow_cfg.full_reverse);
    case (it.cmd)
      CMD_THROTTLE: begin
        n_throttle++;
        p = longint'(it.pct);
        if (p > 0) begin
          if (drive_dir == DIR_REV) begin
            note_result(CH_THROTTLE, shadow_cfg.full_forward, HOLD_LONG, DIR_REV, 1'b0);
            note_result(CH_THROTTLE, shadow_cfg.neutral, HOLD_LONG, DIR_STOP, 1'b0);
          end
          drive_dir = DIR_FWD;
          note_result(CH_THROTTLE, clip_count(lin_scale(p, 0, 100, n, f)),
                      HOLD_NONE, DIR_FWD, 1'b1);
        end else if (p < 0) begin
          if (drive_dir == DIR_FWD) begin
            note_result(CH_THROTTLE, shadow_cfg.full_reverse, HOLD_LONG, DIR_FWD, 1'b0);
            note_result(CH_THROTTLE, shadow_cfg.neutral, HOLD_LONG, DIR_STOP, 1'b0);
          end
          drive_dir = DIR_REV;
          note_result(CH_THROTTLE, clip_count(lin_scale(p, 0, -100, n, r)),
                      HOLD_NONE, DIR_REV, 1'b1);
        end
      end
      CMD_BRAKE: begin
        n_brake++;
        if (drive_dir == DIR_FWD) begin
          note_result(CH_THROTTLE, shadow_cfg.full_reverse, HOLD_LONG, DIR_FWD, 1'b0);
          note_result(CH_THROTTLE, shadow_cfg.neutral, HOLD_LONG, DIR_STOP, 1'b1);
        end else if (drive_dir == DIR_REV) begin
          note_result(CH_THROTTLE, shadow_cfg.full_forward, HOLD_LONG, DIR_REV, 1'b0);
          note_result(CH_THROTTLE, shadow_cfg.neutral, HOLD_LONG, DIR_STOP, 1'b1);
        end else begin
          note_result(CH_THROTTLE, shadow_cfg.neutral, HOLD_SHORT, DIR_STOP, 1'b1);
        end
        drive_dir = DIR_STOP;
      end
      CMD_STEER: begin
        n_steer++;
        a = longint'(it.angle);
        lo = longint'($signed(shadow_cfg.angle_floor));
        hi = longint'($signed(shadow_cfg.angle_ceiling));
        // floor first, so the ceiling wins when the bounds cross
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        if (hi == lo)
          note_result(CH_STEER, shadow_cfg.steer_right, HOLD_NONE, drive_dir, 1'b1);
        else
          note_result(CH_STEER,
                      clip_count(lin_scale(-a, lo, hi, longint'(shadow_cfg.steer_right),
                                           longint'(shadow_cfg.steer_left))),
                      HOLD_NONE, drive_dir, 1'b1);
      end
      default: n_unused++;
    endcase
  endfunction

  function automatic void compare_field(string what, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
      fail_count++;
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        sequence_command(cmd_backlog[0]);
        void'(cmd_backlog.pop_front());
        send_gap = pick_gap(send_steady);
      end
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        push <= 1'b1;
        command <= cmd_backlog[0].cmd;
        throttle_percent <= cmd_backlog[0].pct;
        steer_angle <= cmd_backlog[0].angle;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_checked++;
        if (pwm_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, got ch %0d count %0d", $time,
                   channel, pwm_count);
          fail_count++;
        end else begin
          want = pwm_expected.pop_front();
          compare_field("channel", want.channel, channel);
          compare_field("pwm_count", want.pwm_count, pwm_count);
          compare_field("wait_after", want.wait_after, wait_after);
          compare_field("drive_direction", longint'(want.drive_direction),
                        longint'(drive_direction));
          compare_field("last", want.last, last);
        end
        take_gap = pick_gap(take_steady);
      end
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, int pct, int angle);
    cmd_item_t it;
    it.cmd = cmd;
    it.pct = PCT_W'(pct);
    it.angle = ANG_W'(angle);
    @(negedge clk);
    cmd_backlog.push_back(it);
  endtask

  function automatic cmd_item_t random_cmd();
    cmd_item_t it;
    int roll;
    // unused fields carry noise
    it.pct = PCT_W'($urandom);
    it.angle = ANG_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      it.cmd = CMD_THROTTLE;
      roll = $urandom_range(0, 9);
      if (roll == 0) it.pct = '0;
      else if (roll > 2) it.pct = PCT_W'(int'($urandom_range(0, 200)) - 100);
    end else if (roll < 60) begin
      it.cmd = CMD_BRAKE;
    end else if (roll < 95) begin
      it.cmd = CMD_STEER;
      if ($urandom_range(0, 4) != 0) it.angle = ANG_W'(int'($urandom_range(0, 360)) - 180);
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  function automatic logic [CNT_W-1:0] random_count();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CNT_W'($urandom);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    int lo, hi, tmp, roll;
    s.neutral = random_count();
    s.full_forward = random_count();
    s.full_reverse = random_count();
    s.steer_right = random_count();
    s.steer_left = random_count();
    lo = int'($urandom_range(0, 360)) - 180;
    hi = int'($urandom_range(0, 360)) - 180;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      hi = lo;
    end else if (roll < 20) begin
      lo = -256;
      hi = 255;
    end else if ((roll < 30) == (lo < hi)) begin
      // crossed bounds now and then, ordered otherwise
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    s.angle_floor = ANG_W'(lo);
    s.angle_ceiling = ANG_W'(hi);
    return s;
  endfunction

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic load_settings(cfg_t s);
    put_reg(REG_NEUTRAL, s.neutral);
    put_reg(REG_FULL_FORWARD, s.full_forward);
    put_reg(REG_FULL_REVERSE, s.full_reverse);
    put_reg(REG_STEER_RIGHT, s.steer_right);
    put_reg(REG_STEER_LEFT, s.steer_left);
    put_reg(REG_ANGLE_FLOOR, CFG_DATA_W'(s.angle_floor));
    put_reg(REG_ANGLE_CEILING, CFG_DATA_W'(s.angle_ceiling));
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_cfg = s;
    settings_loaded++;
  endtask

  // hold off until every transaction has drained, then let the back end settle
  task automatic wait_idle();
    int spin;
    spin = 0;
    while ((cmd_backlog.size() != 0 || push || pwm_expected.size() != 0) &&
           spin < DRAIN_LIMIT) begin
      @(negedge clk);
      spin++;
    end
    if (pwm_expected.size() != 0) begin
      $display("%0t: %0d expected results never arrived, expected ch %0d count %0d",
               $time, pwm_expected.size(), pwm_expected[0].channel,
               pwm_expected[0].pwm_count);
      fail_count++;
      pwm_expected.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register defaults: brake from rest, steer bounds, every direction change
    queue_cmd(CMD_BRAKE, 0, 0);
    queue_cmd(CMD_STEER, 0, 0);
    queue_cmd(CMD_STEER, 0, -256);
    queue_cmd(CMD_STEER, 0, 255);
    queue_cmd(CMD_STEER, 0, 60);
    queue_cmd(CMD_STEER, 0, -61);
    queue_cmd(CMD_THROTTLE, 0, 0);
    queue_cmd(CMD_UNUSED, -1, -1);
    queue_cmd(CMD_THROTTLE, 100, 0);
    queue_cmd(CMD_THROTTLE, -1, 0);
    queue_cmd(CMD_THROTTLE, -128, 0);
    queue_cmd(CMD_BRAKE, 0, 0);
    queue_cmd(CMD_THROTTLE, 127, 0);
    queue_cmd(CMD_BRAKE, 0, 0);
    queue_cmd(CMD_THROTTLE, -100, 0);
    queue_cmd(CMD_THROTTLE, 1, 0);
    wait_idle();

    // extreme counts, widest angle span: throttle saturates high
    load_settings('{neutral: '0, full_forward: '1, full_reverse: '1, steer_right: '0,
                    steer_left: '1, angle_floor: -256, angle_ceiling: 255});
    queue_cmd(CMD_THROTTLE, 127, 0);
    queue_cmd(CMD_THROTTLE, -128, 0);
    queue_cmd(CMD_STEER, 0, -256);
    queue_cmd(CMD_STEER, 0, 255);
    wait_idle();

    // mirrored counts, crossed bounds: throttle saturates low
    load_settings('{neutral: '1, full_forward: '0, full_reverse: '0, steer_right: '1,
                    steer_left: '0, angle_floor: 255, angle_ceiling: -256});
    queue_cmd(CMD_THROTTLE, 127, 0);
    queue_cmd(CMD_THROTTLE, -128, 0);
    queue_cmd(CMD_STEER, 0, -200);
    wait_idle();

    // bounds equal: no span to map over
    load_settings('{neutral: RST_NEUTRAL, full_forward: RST_FORWARD,
                    full_reverse: RST_REVERSE, steer_right: RST_RIGHT,
                    steer_left: RST_LEFT, angle_floor: 17, angle_ceiling: 17});
    queue_cmd(CMD_STEER, 0, 17);
    queue_cmd(CMD_STEER, 0, -256);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      load_settings(random_settings());
      for (int k = 0; k < 20; k++) begin
        @(negedge clk);
        cmd_backlog.push_back(random_cmd());
      end
      wait_idle();
    end

    $display("covered %0d commands: %0d throttle, %0d brake, %0d steer, %0d unused code",
             n_throttle + n_brake + n_steer + n_unused, n_throttle, n_brake, n_steer,
             n_unused);
    $display("%0d results checked over %0d register settings", results_checked,
             settings_loaded + 1);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
